/* src/mfa_pkg.sv */
// shared widths, operation codes and divider handshake types for the modular field alu
package mfa_pkg;

    localparam int VW    = 16;              // operand and modulus width
    localparam int DW    = 2 * VW;          // dividend width of the shared divider
    localparam int CNT_W = $clog2(DW + 1);  // divider step counter
    localparam int CW    = VW + 2;          // signed euclid coefficient width
    localparam int PW    = VW + 1 + CW;     // signed product width

    localparam logic [VW-1:0] MOD_RESET = VW'(65521);

    localparam logic [1:0] ACT_ADD = 2'd0;
    localparam logic [1:0] ACT_SUB = 2'd1;
    localparam logic [1:0] ACT_MUL = 2'd2;
    localparam logic [1:0] ACT_DIV = 2'd3;

    typedef struct packed {
        logic          start;
        logic          long_op;   // full DW-bit dividend instead of VW bits
        logic [DW-1:0] dividend;
        logic [VW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic          done;
        logic          busy;
        logic [VW-1:0] quotient;
        logic [VW-1:0] remainder;
    } div_rsp_t;

endpackage

/* src/mfa_divider.sv */
// shared restoring divider, one quotient bit per cycle
module mfa_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  mfa_pkg::div_req_t req,
    output mfa_pkg::div_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [mfa_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [mfa_pkg::DW-1:0]    dvd_reg, dvd_next;
    logic [mfa_pkg::VW-1:0]    rem_reg, rem_next;
    logic [mfa_pkg::VW-1:0]    dsr_reg, dsr_next;

    logic [mfa_pkg::VW:0]      trial;
    logic [mfa_pkg::VW:0]      diff;
    logic                      fits;

    always_comb begin
        trial = {rem_reg, dvd_reg[mfa_pkg::DW-1]};
        diff  = trial - {1'b0, dsr_reg};
        fits  = trial >= {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (req.start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = req.divisor;
            if (req.long_op) begin
                dvd_next = req.dividend;
                cnt_next = mfa_pkg::CNT_W'(mfa_pkg::DW);
            end else begin
                // short dividend sits in the upper half so it shifts out first
                dvd_next = {req.dividend[mfa_pkg::VW-1:0], {mfa_pkg::VW{1'b0}}};
                cnt_next = mfa_pkg::CNT_W'(mfa_pkg::VW);
            end
        end else if (busy_reg) begin
            rem_next = fits ? diff[mfa_pkg::VW-1:0] : trial[mfa_pkg::VW-1:0];
            dvd_next = {dvd_reg[mfa_pkg::DW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == mfa_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.busy      = busy_reg;
    assign rsp.quotient  = dvd_reg[mfa_pkg::VW-1:0];
    assign rsp.remainder = rem_reg;

endmodule

/* src/modular_field_alu_core.sv */
// modular field alu: sequencer, shared multiplier and the divider it drives
//
//  channel | direction | ports
//  --------+-----------+--------------------------------------------------
//  s_      | in        | s_valid s_ready s_action s_first_operand s_second_operand
//  m_      | out       | m_valid m_ready m_result m_error
//  cfg_    | in        | cfg_wr_en cfg_wr_data (modulus)
//
//  every divider pass, the product reduction included, runs on the one divider
//  add/sub reduce both operands; multiply adds a product and its reduction
//  divide adds euclid rounds of divide, multiply and update (about 24 rounds at most
//  for 16 bits); a divisor with no inverse skips the final product reduction
//  s_ready is high only while idle; a finished result waits in the output register
//  modulus resets to 65521; reset is synchronous, active low
module modular_field_alu_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic [mfa_pkg::VW-1:0] s_first_operand,
    input  logic [mfa_pkg::VW-1:0] s_second_operand,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [mfa_pkg::VW-1:0] m_result,
    output logic                   m_error,
    input  logic                   cfg_wr_en,
    input  logic [mfa_pkg::VW-1:0] cfg_wr_data
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_RED_A   = 4'd1;
    localparam logic [3:0] ST_RED_B   = 4'd2;
    localparam logic [3:0] ST_MUL_P   = 4'd3;
    localparam logic [3:0] ST_MUL_RED = 4'd4;
    localparam logic [3:0] ST_EUC_DIV = 4'd5;
    localparam logic [3:0] ST_EUC_MUL = 4'd6;
    localparam logic [3:0] ST_EUC_UPD = 4'd7;
    localparam logic [3:0] ST_EUC_END = 4'd8;
    localparam logic [3:0] ST_OUT     = 4'd9;

    logic [3:0]                    state_reg, state_next;
    logic                          start_reg, start_next;
    logic [mfa_pkg::VW-1:0]        mod_reg, mod_next;
    logic                          m_valid_reg, m_valid_next;
    logic [mfa_pkg::VW-1:0]        m_result_reg, m_result_next;
    logic                          m_error_reg, m_error_next;

    logic [1:0]                    act_reg, act_next;
    logic [mfa_pkg::VW-1:0]        ain_reg, ain_next;
    logic [mfa_pkg::VW-1:0]        bin_reg, bin_next;
    logic [mfa_pkg::VW-1:0]        a_reg, a_next;
    logic [mfa_pkg::VW-1:0]        b_reg, b_next;
    logic [mfa_pkg::VW-1:0]        r0_reg, r0_next;
    logic [mfa_pkg::VW-1:0]        r1_reg, r1_next;
    logic [mfa_pkg::VW-1:0]        rn_reg, rn_next;
    logic [mfa_pkg::VW-1:0]        quo_reg, quo_next;
    logic signed [mfa_pkg::CW-1:0] c0_reg, c0_next;
    logic signed [mfa_pkg::CW-1:0] c1_reg, c1_next;
    logic [mfa_pkg::VW-1:0]        res_reg, res_next;
    logic                          err_reg, err_next;
    logic signed [mfa_pkg::PW-1:0] prod_reg;

    logic signed [mfa_pkg::VW:0]   mul_x;
    logic signed [mfa_pkg::CW-1:0] mul_y;
    logic [mfa_pkg::VW:0]          add_sum;
    logic [mfa_pkg::VW:0]          add_wrap;
    logic [mfa_pkg::VW:0]          sub_wrap;
    logic [mfa_pkg::VW-1:0]        add_res;
    logic [mfa_pkg::VW-1:0]        sub_res;
    logic signed [mfa_pkg::CW-1:0] c0_fix;
    logic [mfa_pkg::VW-1:0]        inv_val;
    logic [mfa_pkg::VW-1:0]        bval;

    mfa_pkg::div_req_t div_req;
    mfa_pkg::div_rsp_t div_rsp;

    mfa_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // divider operands follow the state that the start pulse lands in
    always_comb begin
        div_req.start    = start_reg;
        div_req.long_op  = 1'b0;
        div_req.dividend = {{mfa_pkg::VW{1'b0}}, ain_reg};
        div_req.divisor  = mod_reg;
        case (state_reg)
            ST_RED_B: begin
                div_req.dividend = {{mfa_pkg::VW{1'b0}}, bin_reg};
            end
            ST_MUL_RED: begin
                div_req.long_op  = 1'b1;
                div_req.dividend = prod_reg[mfa_pkg::DW-1:0];
            end
            ST_EUC_DIV: begin
                div_req.dividend = {{mfa_pkg::VW{1'b0}}, r0_reg};
                div_req.divisor  = r1_reg;
            end
            default: begin
            end
        endcase
    end

    // the one multiplier: a*b for products, quotient*coefficient in euclid rounds
    always_comb begin
        if (state_reg == ST_EUC_MUL) begin
            mul_x = $signed({1'b0, quo_reg});
            mul_y = c1_reg;
        end else begin
            mul_x = $signed({1'b0, a_reg});
            mul_y = $signed({2'b00, b_reg});
        end
    end

    always_comb begin
        bval     = div_rsp.remainder;
        add_sum  = {1'b0, a_reg} + {1'b0, bval};
        add_wrap = add_sum - {1'b0, mod_reg};
        add_res  = (add_sum >= {1'b0, mod_reg}) ? add_wrap[mfa_pkg::VW-1:0]
                                                : add_sum[mfa_pkg::VW-1:0];
        sub_wrap = {1'b0, a_reg} + {1'b0, mod_reg} - {1'b0, bval};
        sub_res  = (a_reg >= bval) ? (a_reg - bval) : sub_wrap[mfa_pkg::VW-1:0];
        c0_fix   = c0_reg[mfa_pkg::CW-1] ? (c0_reg + $signed({2'b00, mod_reg})) : c0_reg;
        inv_val  = (c0_fix[mfa_pkg::VW-1:0] == mod_reg) ? '0 : c0_fix[mfa_pkg::VW-1:0];
    end

    always_comb begin
        state_next    = state_reg;
        start_next    = 1'b0;
        mod_next      = cfg_wr_en ? cfg_wr_data : mod_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_result_next = m_result_reg;
        m_error_next  = m_error_reg;
        act_next      = act_reg;
        ain_next      = ain_reg;
        bin_next      = bin_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        r0_next       = r0_reg;
        r1_next       = r1_reg;
        rn_next       = rn_reg;
        quo_next      = quo_reg;
        c0_next       = c0_reg;
        c1_next       = c1_reg;
        res_next      = res_reg;
        err_next      = err_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    act_next = s_action;
                    ain_next = s_first_operand;
                    bin_next = s_second_operand;
                    if (mod_reg < mfa_pkg::VW'(2)) begin
                        res_next   = '0;
                        err_next   = 1'b0;
                        state_next = ST_OUT;
                    end else begin
                        start_next = 1'b1;
                        state_next = ST_RED_A;
                    end
                end
            end
            ST_RED_A: begin
                if (div_rsp.done) begin
                    a_next     = div_rsp.remainder;
                    start_next = 1'b1;
                    state_next = ST_RED_B;
                end
            end
            ST_RED_B: begin
                if (div_rsp.done) begin
                    b_next   = bval;
                    err_next = 1'b0;
                    case (act_reg)
                        mfa_pkg::ACT_ADD: begin
                            res_next   = add_res;
                            state_next = ST_OUT;
                        end
                        mfa_pkg::ACT_SUB: begin
                            res_next   = sub_res;
                            state_next = ST_OUT;
                        end
                        mfa_pkg::ACT_MUL: begin
                            state_next = ST_MUL_P;
                        end
                        default: begin
                            if (bval == '0) begin
                                res_next   = '0;
                                err_next   = 1'b1;
                                state_next = ST_OUT;
                            end else begin
                                r0_next    = mod_reg;
                                r1_next    = bval;
                                c0_next    = '0;
                                c1_next    = mfa_pkg::CW'(1);
                                start_next = 1'b1;
                                state_next = ST_EUC_DIV;
                            end
                        end
                    endcase
                end
            end
            ST_MUL_P: begin
                start_next = 1'b1;
                state_next = ST_MUL_RED;
            end
            ST_MUL_RED: begin
                if (div_rsp.done) begin
                    res_next   = div_rsp.remainder;
                    err_next   = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_EUC_DIV: begin
                if (div_rsp.done) begin
                    quo_next   = div_rsp.quotient;
                    rn_next    = div_rsp.remainder;
                    state_next = ST_EUC_MUL;
                end
            end
            ST_EUC_MUL: begin
                state_next = ST_EUC_UPD;
            end
            ST_EUC_UPD: begin
                // coefficients stay within +-modulus, so the low bits are exact
                r0_next = r1_reg;
                r1_next = rn_reg;
                c0_next = c1_reg;
                c1_next = c0_reg - $signed(prod_reg[mfa_pkg::CW-1:0]);
                if (rn_reg == '0) begin
                    state_next = ST_EUC_END;
                end else begin
                    start_next = 1'b1;
                    state_next = ST_EUC_DIV;
                end
            end
            ST_EUC_END: begin
                if (r0_reg != mfa_pkg::VW'(1)) begin
                    res_next   = '0;
                    err_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    b_next     = inv_val;
                    state_next = ST_MUL_P;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_result_next = res_reg;
                    m_error_next  = err_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            mod_reg     <= mfa_pkg::MOD_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            mod_reg     <= mod_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_result_reg <= m_result_next;
        m_error_reg  <= m_error_next;
        act_reg      <= act_next;
        ain_reg      <= ain_next;
        bin_reg      <= bin_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        rn_reg       <= rn_next;
        quo_reg      <= quo_next;
        c0_reg       <= c0_next;
        c1_reg       <= c1_next;
        res_reg      <= res_next;
        err_reg      <= err_next;
        prod_reg     <= mul_x * mul_y;
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;
    assign m_error  = m_error_reg;

`ifndef SYNTHESIS
    // a delivered beat always lies in the field
    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((mod_reg < mfa_pkg::VW'(2)) && (m_result_reg == '0))
                     || ((mod_reg >= mfa_pkg::VW'(2)) && (m_result_reg < mod_reg)))
        else $error("result beat outside 0..modulus-1");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_error_reg) |-> (m_result_reg == '0))
        else $error("error beat with nonzero result");

    a_start_state: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> (state_reg == ST_RED_A) || (state_reg == ST_RED_B)
                   || (state_reg == ST_MUL_RED) || (state_reg == ST_EUC_DIV))
        else $error("divider started outside a divider wait state");

    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!div_rsp.busy && !div_rsp.done))
        else $error("divider active while sequencer idle");
`endif

endmodule

/* dv/mfa_result_checker.sv */
`timescale 1ns / 100ps
// checker for the modular field alu: predicts each answer and compares the result beats
module mfa_result_checker (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [1:0]             s_action,
    input  logic [mfa_pkg::VW-1:0] s_first_operand,
    input  logic [mfa_pkg::VW-1:0] s_second_operand,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [mfa_pkg::VW-1:0] m_result,
    input  logic                   m_error,
    input  logic                   cfg_wr_en,
    input  logic [mfa_pkg::VW-1:0] cfg_wr_data,
    output int                     mismatch_count,
    output int                     answers_pending
);

    typedef struct {
        logic [1:0]             act;
        logic [mfa_pkg::VW-1:0] x;
        logic [mfa_pkg::VW-1:0] y;
        logic [mfa_pkg::VW-1:0] m;
        logic [mfa_pkg::VW-1:0] value;
        logic                   err;
    } field_answer_t;

    field_answer_t          awaited_answers[$];
    logic [mfa_pkg::VW-1:0] field_modulus = mfa_pkg::MOD_RESET;

    function automatic field_answer_t modular_answer(input logic [1:0] act,
                                                     input logic [mfa_pkg::VW-1:0] x,
                                                     input logic [mfa_pkg::VW-1:0] y,
                                                     input logic [mfa_pkg::VW-1:0] m);
        field_answer_t ans;
        longint        mm, a, b, q;
        longint        r_prev, r_cur, r_next, c_prev, c_cur, c_next;
        ans.act   = act;
        ans.x     = x;
        ans.y     = y;
        ans.m     = m;
        ans.value = '0;
        ans.err   = 1'b0;
        // a modulus of zero or one behaves as one: everything collapses to zero
        if (m < 2)
            return ans;
        mm = longint'(m);
        a  = longint'(x) % mm;
        b  = longint'(y) % mm;
        case (act)
            mfa_pkg::ACT_ADD: ans.value = mfa_pkg::VW'((a + b) % mm);
            mfa_pkg::ACT_SUB: ans.value = mfa_pkg::VW'((a + mm - b) % mm);
            mfa_pkg::ACT_MUL: ans.value = mfa_pkg::VW'((a * b) % mm);
            default: begin
                // extended euclid, tracking only the coefficient of the divisor
                r_prev = mm;
                r_cur  = b;
                c_prev = 0;
                c_cur  = 1;
                while (r_cur != 0) begin
                    q      = r_prev / r_cur;
                    r_next = r_prev - q * r_cur;
                    c_next = c_prev - q * c_cur;
                    r_prev = r_cur;
                    r_cur  = r_next;
                    c_prev = c_cur;
                    c_cur  = c_next;
                end
                if (b == 0 || r_prev != 1) begin
                    ans.err = 1'b1;
                end else begin
                    if (c_prev < 0)
                        c_prev = c_prev + mm;
                    ans.value = mfa_pkg::VW'((a * (c_prev % mm)) % mm);
                end
            end
        endcase
        return ans;
    endfunction

    always @(posedge aclk) begin
        field_answer_t want;
        if (!aresetn) begin
            field_modulus = mfa_pkg::MOD_RESET;
            awaited_answers.delete();
        end else begin
            if (s_valid && s_ready)
                awaited_answers.push_back(modular_answer(s_action, s_first_operand,
                                                         s_second_operand, field_modulus));
            if (cfg_wr_en)
                field_modulus = cfg_wr_data;
            if (m_valid && m_ready) begin
                if (awaited_answers.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: result %0d error %0d with nothing outstanding",
                                 m_result, m_error);
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_result !== want.value || m_error !== want.err) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch op %0d a %0d b %0d m %0d: exp %0d,%0d got %0d,%0d",
                                     want.act, want.x, want.y, want.m, want.value,
                                     want.err, m_result, m_error);
                    end
                end
            end
        end
        answers_pending = awaited_answers.size();
    end

endmodule

/* dv/modular_field_alu_core_tb.sv */
`timescale 1ns / 100ps
// top of the modular field alu testbench: clock, reset, stimulus and verdict
module modular_field_alu_core_tb;

    localparam int WATCHDOG_LIMIT = 6000;

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   s_valid          = 1'b0;
    logic [1:0]             s_action         = mfa_pkg::ACT_ADD;
    logic [mfa_pkg::VW-1:0] s_first_operand  = '0;
    logic [mfa_pkg::VW-1:0] s_second_operand = '0;
    logic                   m_ready          = 1'b0;
    logic                   cfg_wr_en        = 1'b0;
    logic [mfa_pkg::VW-1:0] cfg_wr_data      = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic [mfa_pkg::VW-1:0] m_result;
    logic                   m_error;

    int mismatch_count;
    int answers_pending;
    int rx_mode     = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit gaps_on     = 1'b0;

    modular_field_alu_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_first_operand  (s_first_operand),
        .s_second_operand (s_second_operand),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result         (m_result),
        .m_error          (m_error),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    mfa_result_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_first_operand  (s_first_operand),
        .s_second_operand (s_second_operand),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result         (m_result),
        .m_error          (m_error),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .mismatch_count   (mismatch_count),
        .answers_pending  (answers_pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver: mode 0 always ready, mode 1 short frequent stalls, mode 2 long rare ones
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_mode == 1 && $urandom_range(0, 99) < 30) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else if (rx_mode == 2 && $urandom_range(0, 99) < 10) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(4, 59);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // counts cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_op(input logic [1:0] act, input logic [mfa_pkg::VW-1:0] x,
                           input logic [mfa_pkg::VW-1:0] y);
        s_valid          <= 1'b1;
        s_action         <= act;
        s_first_operand  <= x;
        s_second_operand <= y;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        // beat taken; maybe close the burst with a gap
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 10);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (answers_pending != 0)
            @(posedge aclk);
    endtask

    task automatic set_modulus(input logic [mfa_pkg::VW-1:0] value);
        wait_idle();
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [mfa_pkg::VW-1:0] pick_operand(input logic [mfa_pkg::VW-1:0] m);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return m - 1'b1;
            2:       return m;
            3:       return '1;
            4:       return mfa_pkg::VW'($urandom_range(0, 40));
            5:       return m + mfa_pkg::VW'($urandom_range(1, 5));
            default: return mfa_pkg::VW'($urandom);
        endcase
    endfunction

    task automatic run_random(input logic [mfa_pkg::VW-1:0] m, input int count,
                              input int mode, input bit gaps);
        int n;
        set_modulus(m);
        rx_mode    = mode;
        gaps_on    = gaps;
        burst_left = 0;
        for (n = 0; n < count; n++) begin
            send_op(2'($urandom_range(0, 3)), pick_operand(m), pick_operand(m));
            // now and then let the pipe run dry before carrying on
            if ($urandom_range(0, 49) == 0)
                wait_idle();
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset modulus, operands at and above the modulus
        send_op(mfa_pkg::ACT_ADD, 16'hFFFF, 16'hFFFF);
        send_op(mfa_pkg::ACT_ADD, 16'd65520, 16'd1);
        send_op(mfa_pkg::ACT_SUB, 16'd0, 16'd1);
        send_op(mfa_pkg::ACT_SUB, 16'd65521, 16'd0);
        send_op(mfa_pkg::ACT_MUL, 16'hFFFF, 16'hFFFF);
        send_op(mfa_pkg::ACT_MUL, 16'd65520, 16'd65520);
        send_op(mfa_pkg::ACT_DIV, 16'd1, 16'd65520);
        send_op(mfa_pkg::ACT_DIV, 16'hFFFF, 16'd0);
        send_op(mfa_pkg::ACT_DIV, 16'd5, 16'd65521);
        send_op(mfa_pkg::ACT_DIV, 16'd0, 16'd7);

        // modulus below two collapses every answer, divide included
        set_modulus(16'd0);
        send_op(mfa_pkg::ACT_DIV, 16'd7, 16'd3);
        send_op(mfa_pkg::ACT_ADD, 16'hFFFF, 16'hFFFF);
        send_op(mfa_pkg::ACT_MUL, 16'hFFFF, 16'd2);
        set_modulus(16'd1);
        send_op(mfa_pkg::ACT_DIV, 16'd1, 16'd0);
        send_op(mfa_pkg::ACT_SUB, 16'd0, 16'hFFFF);

        // composite modulus: divisor sharing a factor is not invertible
        set_modulus(16'hFFFF);
        send_op(mfa_pkg::ACT_DIV, 16'd10, 16'd3);
        send_op(mfa_pkg::ACT_DIV, 16'd10, 16'd2);
        send_op(mfa_pkg::ACT_DIV, 16'hFFFF, 16'hFFFE);
        send_op(mfa_pkg::ACT_SUB, 16'd0, 16'hFFFF);

        set_modulus(16'd2);
        send_op(mfa_pkg::ACT_DIV, 16'd1, 16'd1);
        send_op(mfa_pkg::ACT_MUL, 16'd1, 16'd1);
        send_op(mfa_pkg::ACT_ADD, 16'd1, 16'd1);

        run_random(mfa_pkg::MOD_RESET, 80, 0, 1'b0);
        run_random(16'd2, 70, 1, 1'b1);
        run_random(16'hFFFF, 80, 2, 1'b1);
        run_random(16'd3, 60, 1, 1'b0);
        run_random(16'd1024, 80, 2, 1'b1);
        run_random(16'd251, 80, 1, 1'b1);
        run_random(mfa_pkg::VW'($urandom_range(2, 300)), 60, 2, 1'b1);
        run_random(mfa_pkg::VW'($urandom_range(2, 65535)), 80, 1, 1'b1);
        run_random(16'd65521, 60, 2, 1'b1);

        wait_idle();
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && answers_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
